// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque: sizes, codes and controller/datapath structs.
`timescale 1ns / 1ps
package cdq_pkg;

    localparam int DEPTH   = 256;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 9;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_mode MODE_PUSH_REAR  = 2'd0;
    localparam t_mode MODE_PUSH_FRONT = 2'd1;
    localparam t_mode MODE_POP_FRONT  = 2'd2;
    localparam t_mode MODE_POP_REAR   = 2'd3;

    localparam t_status STATUS_OK        = 2'd0;
    localparam t_status STATUS_OVERFLOW  = 2'd1;
    localparam t_status STATUS_UNDERFLOW = 2'd2;

    // Controller -> datapath.
    typedef struct packed {
        logic    exec;    // perform the request this cycle
        logic    ok;      // request succeeds (no overflow/underflow)
        t_mode   mode;
        t_status status;
    } t_cmd;

    // Datapath -> controller.
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

// ----- rtl/cdq_ctrl.sv -----
// Controller FSM for the circular deque: accepts requests, decides outcome, strobes result.
`timescale 1ns / 1ps
module cdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cdq_pkg::t_mode    i_mode,
    input  cdq_pkg::t_dp_stat i_stat,
    output cdq_pkg::t_cmd     o_cmd,
    output logic              o_done
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DONE = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign busy   = (r_state == ST_DONE);
    assign o_done = (r_state == ST_DONE);
    assign accept = start && (r_state == ST_IDLE);

    always_comb begin
        o_cmd.exec   = accept;
        o_cmd.mode   = i_mode;
        o_cmd.ok     = 1'b1;
        o_cmd.status = cdq_pkg::STATUS_OK;
        case (i_mode)
            cdq_pkg::MODE_PUSH_REAR, cdq_pkg::MODE_PUSH_FRONT: begin
                if (i_stat.full) begin
                    o_cmd.ok     = 1'b0;
                    o_cmd.status = cdq_pkg::STATUS_OVERFLOW;
                end
            end
            default: begin
                if (i_stat.empty) begin
                    o_cmd.ok     = 1'b0;
                    o_cmd.status = cdq_pkg::STATUS_UNDERFLOW;
                end
            end
        endcase
    end

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = accept ? ST_DONE : ST_IDLE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/cdq_dp.sv -----
// Datapath for the circular deque: entry memory, head/tail indices, capacity, result registers.
`timescale 1ns / 1ps
module cdq_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cdq_pkg::t_cmd                      i_cmd,
    input  logic                               i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]          i_cfg_wdata,
    input  logic signed [cdq_pkg::VALUE_W-1:0] i_push_value,
    output cdq_pkg::t_dp_stat                  o_stat,
    output logic signed [cdq_pkg::VALUE_W-1:0] o_pop_value,
    output cdq_pkg::t_status                   o_status
);

    logic [cdq_pkg::VALUE_W-1:0] r_mem [cdq_pkg::DEPTH];

    logic [cdq_pkg::IDX_W-1:0]   r_head, n_head;
    logic [cdq_pkg::IDX_W-1:0]   r_tail, n_tail;
    logic                        r_empty, n_empty;
    logic [cdq_pkg::IDX_W-1:0]   r_cap_m1;     // capacity in use minus one
    logic [cdq_pkg::VALUE_W-1:0] r_rd_data;
    logic                        r_popped;
    cdq_pkg::t_status            r_status;

    logic [cdq_pkg::IDX_W-1:0]   head_up, head_dn, tail_up, tail_dn;
    logic [cdq_pkg::IDX_W-1:0]   wr_addr, rd_addr;
    logic                        wr_en, is_pop;
    logic [cdq_pkg::IDX_W-1:0]   cap_m1_new;

    assign head_up = (r_head >= r_cap_m1) ? '0 : r_head + 1'b1;
    assign tail_up = (r_tail >= r_cap_m1) ? '0 : r_tail + 1'b1;
    assign head_dn = (r_head == '0) ? r_cap_m1 : r_head - 1'b1;
    assign tail_dn = (r_tail == '0) ? r_cap_m1 : r_tail - 1'b1;

    assign o_stat.empty = r_empty;
    assign o_stat.full  = !r_empty && (tail_up == r_head);

    assign is_pop  = (i_cmd.mode == cdq_pkg::MODE_POP_FRONT) ||
                     (i_cmd.mode == cdq_pkg::MODE_POP_REAR);
    assign wr_en   = i_cmd.exec && i_cmd.ok && !is_pop;
    assign rd_addr = (i_cmd.mode == cdq_pkg::MODE_POP_FRONT) ? r_head : r_tail;

    // Push into an empty deque restarts at entry 0.
    always_comb begin
        if (r_empty) begin
            wr_addr = '0;
        end else if (i_cmd.mode == cdq_pkg::MODE_PUSH_FRONT) begin
            wr_addr = head_dn;
        end else begin
            wr_addr = tail_up;
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_empty = r_empty;
        if (i_cmd.exec && i_cmd.ok) begin
            case (i_cmd.mode)
                cdq_pkg::MODE_PUSH_REAR: begin
                    n_empty = 1'b0;
                    if (r_empty) begin
                        n_head = '0;
                        n_tail = '0;
                    end else begin
                        n_tail = tail_up;
                    end
                end
                cdq_pkg::MODE_PUSH_FRONT: begin
                    n_empty = 1'b0;
                    if (r_empty) begin
                        n_head = '0;
                        n_tail = '0;
                    end else begin
                        n_head = head_dn;
                    end
                end
                cdq_pkg::MODE_POP_FRONT: begin
                    if (r_head == r_tail) n_empty = 1'b1;
                    else                  n_head  = head_up;
                end
                default: begin
                    if (r_head == r_tail) n_empty = 1'b1;
                    else                  n_tail  = tail_dn;
                end
            endcase
        end
    end

    // Capacity 0 acts as 1, anything above the store depth acts as the depth.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cap_m1_new = '0;
        end else if (i_cfg_wdata > cdq_pkg::CAP_W'(cdq_pkg::DEPTH)) begin
            cap_m1_new = cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
        end else begin
            cap_m1_new = cdq_pkg::IDX_W'(i_cfg_wdata - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_cap_m1 <= cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
            r_popped <= 1'b0;
        end else if (i_cfg_we) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_cap_m1 <= cap_m1_new;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            if (i_cmd.exec) r_popped <= i_cmd.ok && is_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_status <= i_cmd.status;
    end

    // Entry memory with one write port and one read port, registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= i_push_value;
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_pop_value = r_popped ? signed'(r_rd_data) : '0;
    assign o_status    = r_status;

endmodule

// ----- rtl/circular_deque_top.sv -----
// Top level of the circular deque: controller and datapath.
// Latency: a request accepted at edge N shows its result (o_done high) in the cycle after N.
// The block takes no new request while it shows a result: busy is high during the result cycle,
// set by the controller's done state.
// Reset: synchronous active-low; deque empty, head/tail 0, capacity 256. Memory not cleared.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
`timescale 1ns / 1ps
module circular_deque_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               start,
    output logic                               busy,
    input  logic [cdq_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [cdq_pkg::VALUE_W-1:0] i_push_value,
    // capacity register
    input  logic                               i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]          i_cfg_wdata,
    // result channel
    output logic                               o_done,
    output logic signed [cdq_pkg::VALUE_W-1:0] o_pop_value,
    output logic [cdq_pkg::STAT_W-1:0]         o_status
);

    cdq_pkg::t_cmd     cmd;    // controller decision for the current request
    cdq_pkg::t_dp_stat stat;   // empty/full flags from the index registers

    // Controller: decodes the request against empty/full and sequences the result strobe.
    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_done  (o_done)
    );

    // Datapath: memory access, index updates, capacity register and result registers.
    cdq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push_value (i_push_value),
        .o_stat       (stat),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status)
    );

endmodule

// ----- rtl/cdq_chk.sv -----
// Port-level checker for the circular deque, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cdq_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_done,
    input logic signed [cdq_pkg::VALUE_W-1:0] o_pop_value,
    input logic [cdq_pkg::STAT_W-1:0]         o_status
);

    `ASSERT_CLK(a_done_follows_req, i_clk, i_rst_n, (start && !busy) |=> o_done, "request without result")
    `ASSERT_CLK(a_done_has_req, i_clk, i_rst_n, o_done |-> $past(start && !busy), "result without request")
    `ASSERT_NEVER(a_status_code, i_clk, i_rst_n, o_done && (o_status != cdq_pkg::STATUS_OK) && (o_status != cdq_pkg::STATUS_OVERFLOW) && (o_status != cdq_pkg::STATUS_UNDERFLOW), "bad status code")
    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n, (o_done && (o_status != cdq_pkg::STATUS_OK)) |-> (o_pop_value == '0), "failed request returned data")

endmodule

bind circular_deque_top cdq_chk u_cdq_chk (.*);

// ----- bench/deque_result_checker.sv -----
`timescale 1ns / 1ps
// Checker for the circular deque: shadow deque, expected results and comparison.
module deque_result_checker
    import cdq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic signed [VALUE_W-1:0] i_push_value,
    input  logic                      i_cfg_we,
    input  logic [CAP_W-1:0]          i_cfg_wdata,
    input  logic                      i_done,
    input  logic signed [VALUE_W-1:0] i_pop_value,
    input  logic [STAT_W-1:0]         i_status,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_overflows,
    output int                        o_underflows
);

    typedef struct packed {
        logic [VALUE_W-1:0] pop_value;
        t_status            status;
    } deque_result_t;

    // shadow copy of the deque
    logic [VALUE_W-1:0] shadow_store [DEPTH];
    int unsigned        front_idx = 0;
    int unsigned        rear_idx = 0;
    logic               shadow_empty = 1'b1;
    logic [CAP_W-1:0]   shadow_cap = 9'd256;

    deque_result_t expected_results [$];
    int            fail_count = 0;
    int            checked = 0;
    int            overflows = 0;
    int            underflows = 0;

    // 0 behaves as 1, anything above the store depth as the depth
    function automatic int unsigned cap_limit();
        if (shadow_cap == 0) return 1;
        if (shadow_cap > DEPTH) return DEPTH;
        return shadow_cap;
    endfunction

    function automatic int unsigned next_slot(int unsigned i);
        return (i >= cap_limit() - 1) ? 0 : i + 1;
    endfunction

    function automatic int unsigned prev_slot(int unsigned i);
        return (i == 0) ? cap_limit() - 1 : i - 1;
    endfunction

    function automatic deque_result_t apply_request(t_mode mode, logic [VALUE_W-1:0] value);
        deque_result_t res;
        res.pop_value = '0;
        res.status    = STATUS_OK;
        if (mode == MODE_PUSH_REAR || mode == MODE_PUSH_FRONT) begin
            if (!shadow_empty && next_slot(rear_idx) == front_idx) begin
                res.status = STATUS_OVERFLOW;
            end else if (shadow_empty) begin
                // first entry always lands in slot 0
                front_idx       = 0;
                rear_idx        = 0;
                shadow_empty    = 1'b0;
                shadow_store[0] = value;
            end else if (mode == MODE_PUSH_REAR) begin
                rear_idx               = next_slot(rear_idx);
                shadow_store[rear_idx] = value;
            end else begin
                front_idx               = prev_slot(front_idx);
                shadow_store[front_idx] = value;
            end
        end else begin
            if (shadow_empty) begin
                res.status = STATUS_UNDERFLOW;
            end else if (mode == MODE_POP_FRONT) begin
                res.pop_value = shadow_store[front_idx];
                if (front_idx == rear_idx) shadow_empty = 1'b1;
                else front_idx = next_slot(front_idx);
            end else begin
                res.pop_value = shadow_store[rear_idx];
                if (front_idx == rear_idx) shadow_empty = 1'b1;
                else rear_idx = prev_slot(rear_idx);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        deque_result_t exp_res;
        if (!i_rst_n) begin
            front_idx    = 0;
            rear_idx     = 0;
            shadow_empty = 1'b1;
            shadow_cap   = 9'd256;
            expected_results.delete();
        end else begin
            // completed request first, so a same-edge accept cannot match it
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] result with no request outstanding: pop_value %h status %0d",
                                 $realtime, i_pop_value, i_status);
                end else begin
                    exp_res = expected_results.pop_front();
                    checked++;
                    if (exp_res.status == STATUS_OVERFLOW) overflows++;
                    if (exp_res.status == STATUS_UNDERFLOW) underflows++;
                    if (i_pop_value !== exp_res.pop_value || i_status !== exp_res.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] request %0d: pop_value exp %h got %h, status exp %0d got %0d",
                                     $realtime, checked, exp_res.pop_value, i_pop_value,
                                     exp_res.status, i_status);
                    end
                end
            end
            if (i_cfg_we) begin
                // capacity write flushes the deque
                shadow_cap   = i_cfg_wdata;
                front_idx    = 0;
                rear_idx     = 0;
                shadow_empty = 1'b1;
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_request(i_mode, i_push_value));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
        o_overflows  <= overflows;
        o_underflows <= underflows;
    end

endmodule

// ----- bench/tb_circular_deque_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the circular deque: clock, reset, request stimulus and verdict.
module tb_circular_deque_top;
    import cdq_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int TIMEOUT_NS = 2_000_000;   // far above the slowest legal run
    localparam int RAND_PHASES = 8;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [MODE_W-1:0]         i_mode;
    logic signed [VALUE_W-1:0] i_push_value;
    logic                      i_cfg_we;
    logic [CAP_W-1:0]          i_cfg_wdata;
    logic                      o_done;
    logic signed [VALUE_W-1:0] o_pop_value;
    logic [STAT_W-1:0]         o_status;

    int fail_count;
    int pending;
    int checked;
    int overflows;
    int underflows;

    int idle_pct = 0;     // chance, in percent, of a gap before each request
    int cap_writes = 0;

    circular_deque_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status)
    );

    deque_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_done       (o_done),
        .i_pop_value  (o_pop_value),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_overflows  (overflows),
        .o_underflows (underflows)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL circular_deque_top");
        $finish;
    end

    // Issue one request and return at the edge that accepts it. An optional
    // random gap comes first; start stays high across back-to-back requests
    // so it is never dropped and raised in the same step.
    task automatic send_request(t_mode mode, logic [VALUE_W-1:0] value);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_push_value <= value;
        // accepted at the first edge where busy was low
        do @(posedge i_clk); while (busy);
    endtask

    // Capacity write, only with the block drained. pending is read before
    // the checker's update at the same edge, hence the loop plus slack.
    task automatic set_capacity(logic [CAP_W-1:0] cap);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    initial begin
        logic [CAP_W-1:0]   phase_caps [RAND_PHASES];
        int                 idle_plan [4];
        int                 n_items;
        int                 push_pct;
        logic [VALUE_W-1:0] value;
        t_mode              mode;

        // no idling / heavy sender gaps / receiver cannot stall, so none / light gaps
        idle_plan  = '{0, 67, 0, 15};
        // small rings mostly, one full-depth run that fills and wraps,
        // plus out-of-range settings (0 and above depth)
        phase_caps = '{9'd2, 9'd256, 9'd1, 9'd3, 9'd511, 9'd0, 9'd7, 9'd300};

        start        = 1'b0;
        i_mode       = MODE_PUSH_REAR;
        i_push_value = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_rst_n      = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: reset capacity (256) ----
        send_request(MODE_POP_FRONT, 32'h0);          // underflow on empty
        send_request(MODE_POP_REAR, 32'hdead_beef);   // underflow, value ignored
        send_request(MODE_PUSH_REAR, 32'h7fff_ffff);  // push into empty -> slot 0
        send_request(MODE_PUSH_FRONT, 32'h8000_0000); // front wraps 0 -> 255
        send_request(MODE_PUSH_REAR, 32'hffff_ffff);
        send_request(MODE_PUSH_FRONT, 32'h0);
        send_request(MODE_POP_REAR, 32'h0);
        send_request(MODE_POP_FRONT, 32'h0);
        send_request(MODE_POP_FRONT, 32'h0);          // front wraps 255 -> 0
        send_request(MODE_POP_REAR, 32'h0);           // last element, deque empty
        send_request(MODE_POP_FRONT, 32'h0);          // underflow again

        // ---- single-entry ring ----
        set_capacity(9'd1);
        send_request(MODE_PUSH_FRONT, 32'h5a5a_5a5a);
        send_request(MODE_PUSH_REAR, 32'h1111_1111);  // overflow
        send_request(MODE_POP_FRONT, 32'h0);

        // ---- zero capacity behaves as one ----
        set_capacity(9'd0);
        send_request(MODE_PUSH_REAR, 32'ha5a5_a5a5);
        send_request(MODE_PUSH_FRONT, 32'h2222_2222); // overflow
        send_request(MODE_POP_REAR, 32'h0);

        // ---- two entries: both ends wrap ----
        set_capacity(9'd2);
        send_request(MODE_PUSH_FRONT, 32'h1);
        send_request(MODE_PUSH_FRONT, 32'h2);         // front wraps to slot 1
        send_request(MODE_PUSH_REAR, 32'h3);          // overflow
        send_request(MODE_POP_REAR, 32'h0);           // rear wraps down to slot 1
        send_request(MODE_POP_FRONT, 32'h0);          // last element

        // ---- capacity write flushes a non-empty deque ----
        send_request(MODE_PUSH_REAR, 32'h1234_5678);
        set_capacity(9'd511);                         // above depth, acts as 256
        send_request(MODE_POP_FRONT, 32'h0);          // underflow: flushed

        // ---- random phases ----
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_capacity(phase_caps[p]);
            idle_pct = idle_plan[p % 4];
            if (phase_caps[p] == 9'd256) begin
                // push-heavy so the full ring is reached and overflows
                n_items  = 270;
                push_pct = 99;
            end else begin
                n_items  = 25;
                push_pct = $urandom_range(75, 25);
            end
            for (int k = 0; k < n_items; k++) begin
                if ($urandom_range(99) < push_pct)
                    mode = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
                else
                    mode = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR;
                case ($urandom_range(15))
                    0:       value = 32'h0;
                    1:       value = 32'hffff_ffff;
                    2:       value = 32'h7fff_ffff;
                    3:       value = 32'h8000_0000;
                    default: value = $urandom;
                endcase
                send_request(mode, value);
            end
        end

        // drain: wait for the last result, then wait on for stray strobes
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d requests across %0d capacity settings,",
                 checked, cap_writes + 1);
        $display("including %0d overflows and %0d underflows; %0d mismatches.",
                 overflows, underflows, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS circular_deque_top");
        else
            $display("FAIL circular_deque_top");
        $finish;
    end

endmodule
